### rtl/core/msps_pkg.sv
package msps_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam logic [15:0] REFRESH_RST = 16'd20000;
	localparam logic [15:0] DEFAULT_RST = 16'd1500;
	localparam logic [15:0] ANGLE_MAX = 16'd180;
	localparam int DIV_W = 24;
	// floor(x / 45) = (x * RECIP_45) >> RECIP_SH for every x below 2^22
	localparam logic [22:0] RECIP_45 = 23'd5965233;
	localparam int RECIP_SH = 28;

	localparam logic CFG_REFRESH = 1'b0;
	localparam logic CFG_DEFAULT = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK, OP_ATTACH, OP_DETACH, OP_WRITE, OP_WRITE_US, OP_READ_US, OP_READ_DEG, OP_NONE
	} op_t;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NOT_ATTACHED = 2'd1;
	localparam logic [1:0] STAT_ZERO_RANGE = 2'd2;

	typedef enum logic [1:0] {CLS_TICK, CLS_NOP, CLS_BADCH, CLS_CHAN} cls_t;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} back_state_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] channel;
		logic signed [15:0] value;
		logic [15:0] min_us;
		logic [15:0] max_us;
	} item_t;

	typedef struct packed {
		logic [7:0] pulse_lines;
		logic signed [15:0] read_value;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		op_t op;
		cls_t cls;
		logic [2:0] channel;
		logic signed [15:0] value;
		logic [15:0] min_us;
		logic [15:0] max_us;
	} cmd_t;

endpackage

### rtl/core/msps_front.sv
module msps_front #(
	parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input msps_pkg::item_t item,
	output logic full,
	output logic cmd_vld,
	output msps_pkg::cmd_t cmd,
	input logic cmd_take
);

	msps_pkg::cmd_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	msps_pkg::cmd_t cls_cmd;
	logic do_push;

	// classify on entry
	always_comb begin
		cls_cmd.op = msps_pkg::op_t'(item.operation);
		cls_cmd.channel = item.channel;
		cls_cmd.value = item.value;
		cls_cmd.min_us = item.min_us;
		cls_cmd.max_us = item.max_us;
		if (cls_cmd.op == msps_pkg::OP_TICK) begin
			cls_cmd.cls = msps_pkg::CLS_TICK;
		end else if (cls_cmd.op == msps_pkg::OP_NONE) begin
			cls_cmd.cls = msps_pkg::CLS_NOP;
		end else if (int'(item.channel) < CHANNELS) begin
			cls_cmd.cls = msps_pkg::CLS_CHAN;
		end else begin
			cls_cmd.cls = msps_pkg::CLS_BADCH;
		end
	end

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign cmd_vld = (cnt_q != 2'd0);
	assign cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_take) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, cmd_take};
		end
	end

endmodule

### rtl/core/msps_back.sv
module msps_back #(
	parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_vld,
	input msps_pkg::cmd_t cmd,
	output logic cmd_take,
	input logic [15:0] refresh_us,
	input logic [15:0] default_us,
	output logic res_vld,
	output msps_pkg::result_t res,
	input logic res_take
);

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = $clog2(CHANNELS + 1);
	localparam int LW = (CHANNELS > 8) ? CHANNELS : 8;
	localparam int DW = msps_pkg::DIV_W;
	localparam logic [19:0] TOTAL_RST = 20'(CHANNELS * int'(msps_pkg::DEFAULT_RST));

	msps_pkg::back_state_t state_q, state_d;
	logic [SW-1:0] slot_q, slot_d;
	logic [15:0] time_q, time_d;
	logic [CHANNELS-1:0] en_q, en_d;
	logic [15:0] pw_q [CHANNELS];
	logic [15:0] pw_d [CHANNELS];
	logic [15:0] min_q [CHANNELS];
	logic [15:0] min_d [CHANNELS];
	logic [15:0] max_q [CHANNELS];
	logic [15:0] max_d [CHANNELS];
	logic [19:0] total_q, total_d;
	logic [LW-1:0] lines_q, lines_d;
	msps_pkg::op_t op_q, op_d;
	logic [IW-1:0] addr_q, addr_d, rd_addr;
	logic signed [17:0] mul_a_q, mul_a_d;
	logic signed [8:0] mul_b_q, mul_b_d;
	logic [15:0] dvs_q, dvs_d;
	logic dneg_q, dneg_d, neg_q, neg_d;
	logic [15:0] rem_q, rem_d;
	logic [DW-1:0] quo_q, quo_d;
	logic [4:0] cnt_q, cnt_d;
	msps_pkg::result_t res_q, res_d;
	logic res_vld_q, res_vld_d;

	logic load_res;
	logic [15:0] pw_rd, min_rd, max_rd, tl, new_w;
	logic en_rd;
	logic signed [17:0] diff;
	logic signed [26:0] prod, mag;
	logic [16:0] trial;
	logic [44:0] recip;
	logic signed [DW:0] qs;
	logic signed [25:0] wv;

	// raise to min, then lower to max
	function automatic logic [15:0] clamp_w(logic signed [25:0] v, logic [15:0] lo,
			logic [15:0] hi);
		logic signed [25:0] l, h, r;
		l = signed'({10'b0, lo});
		h = signed'({10'b0, hi});
		r = v;
		if (r < l) r = l;
		if (r > h) r = h;
		return r[15:0];
	endfunction

	assign rd_addr = (state_q != msps_pkg::ST_IDLE) ? addr_q :
		(cmd.cls == msps_pkg::CLS_TICK) ? slot_q[IW-1:0] : IW'(cmd.channel);
	assign pw_rd = pw_q[rd_addr];
	assign min_rd = min_q[rd_addr];
	assign max_rd = max_q[rd_addr];
	assign en_rd = en_q[rd_addr];
	assign diff = signed'({2'b0, max_rd}) - signed'({2'b0, min_rd});
	assign res_vld = res_vld_q;
	assign res = res_q;

	always_comb begin
		state_d = state_q;
		slot_d = slot_q;
		time_d = time_q;
		en_d = en_q;
		pw_d = pw_q;
		min_d = min_q;
		max_d = max_q;
		total_d = total_q;
		lines_d = lines_q;
		op_d = op_q;
		addr_d = addr_q;
		mul_a_d = mul_a_q;
		mul_b_d = mul_b_q;
		dvs_d = dvs_q;
		dneg_d = dneg_q;
		neg_d = neg_q;
		rem_d = rem_q;
		quo_d = quo_q;
		cnt_d = cnt_q;
		res_d = res_q;
		res_vld_d = res_vld_q && !res_take;
		cmd_take = 1'b0;
		load_res = 1'b0;
		tl = 16'd0;
		new_w = 16'd0;
		prod = 27'sd0;
		mag = 27'sd0;
		trial = 17'd0;
		recip = 45'd0;
		qs = '0;
		wv = 26'sd0;

		unique case (state_q)
			msps_pkg::ST_IDLE: begin
				if (cmd_vld && (!res_vld_q || res_take)) begin
					cmd_take = 1'b1;
					load_res = 1'b1;
					addr_d = rd_addr;
					op_d = cmd.op;
					res_d.read_value = 16'sd0;
					res_d.status = msps_pkg::STAT_OK;
					case (cmd.cls)
						msps_pkg::CLS_TICK: begin
							tl = (time_q != 16'd0) ? time_q - 16'd1 : time_q;
							time_d = tl;
							if (tl == 16'd0) begin
								if (slot_q < SW'(CHANNELS)) begin
									time_d = pw_rd;
								end else if (total_q < {4'b0, refresh_us}) begin
									time_d = 16'({4'b0, refresh_us} - total_q);
								end else begin
									time_d = default_us;
								end
								// a detached line is already low, so drop unconditionally
								if (slot_q != '0) begin
									lines_d = lines_d & ~(LW'(1) << (slot_q - SW'(1)));
								end
								if (slot_q < SW'(CHANNELS)) begin
									if (en_rd) lines_d = lines_d | (LW'(1) << slot_q);
									slot_d = slot_q + SW'(1);
								end else begin
									slot_d = '0;
								end
							end
						end
						msps_pkg::CLS_NOP: begin
						end
						msps_pkg::CLS_BADCH: begin
							res_d.status = msps_pkg::STAT_NOT_ATTACHED;
						end
						default: begin
							if (cmd.op == msps_pkg::OP_ATTACH) begin
								min_d[rd_addr] = cmd.min_us;
								max_d[rd_addr] = cmd.max_us;
								lines_d = lines_d & ~(LW'(1) << rd_addr);
								en_d[rd_addr] = 1'b1;
							end else if (!en_rd) begin
								res_d.status = msps_pkg::STAT_NOT_ATTACHED;
							end else begin
								case (cmd.op)
									msps_pkg::OP_DETACH: begin
										en_d[rd_addr] = 1'b0;
										pw_d[rd_addr] = default_us;
										total_d = total_q - {4'b0, pw_rd} + {4'b0, default_us};
										lines_d = lines_d & ~(LW'(1) << rd_addr);
									end
									msps_pkg::OP_WRITE, msps_pkg::OP_WRITE_US: begin
										if (cmd.op == msps_pkg::OP_WRITE
												&& cmd.value <= signed'(msps_pkg::ANGLE_MAX)) begin
											// angle: scale over the range, then divide by 180
											mul_a_d = diff;
											mul_b_d = cmd.value[15] ? 9'sd0 : signed'({1'b0, cmd.value[7:0]});
											dvs_d = msps_pkg::ANGLE_MAX;
											dneg_d = 1'b0;
											state_d = msps_pkg::ST_MUL;
											load_res = 1'b0;
										end else begin
											new_w = clamp_w(signed'({{10{cmd.value[15]}}, cmd.value}),
												min_rd, max_rd);
											pw_d[rd_addr] = new_w;
											total_d = total_q - {4'b0, pw_rd} + {4'b0, new_w};
										end
									end
									msps_pkg::OP_READ_US: begin
										res_d.read_value = signed'(pw_rd);
									end
									msps_pkg::OP_READ_DEG: begin
										if (diff == 18'sd0) begin
											res_d.status = msps_pkg::STAT_ZERO_RANGE;
										end else begin
											mul_a_d = signed'({2'b0, pw_rd}) + 18'sd1
												- signed'({2'b0, min_rd});
											mul_b_d = signed'({1'b0, msps_pkg::ANGLE_MAX[7:0]});
											dvs_d = diff[17] ? 16'(-diff) : diff[15:0];
											dneg_d = diff[17];
											state_d = msps_pkg::ST_MUL;
											load_res = 1'b0;
										end
									end
									default: begin
									end
								endcase
							end
						end
					endcase
				end
			end
			msps_pkg::ST_MUL: begin
				prod = mul_a_q * mul_b_q;
				mag = prod[26] ? -prod : prod;
				quo_d = mag[DW-1:0];
				rem_d = 16'd0;
				neg_d = prod[26] ^ dneg_q;
				cnt_d = 5'(DW - 1);
				state_d = msps_pkg::ST_DIV;
			end
			msps_pkg::ST_DIV: begin
				if (op_q == msps_pkg::OP_WRITE) begin
					// divide by 180 in one step: drop two bits, then scale by 1/45
					recip = 45'(quo_q[DW-1:2]) * 45'(msps_pkg::RECIP_45);
					quo_d = DW'(recip[44:msps_pkg::RECIP_SH]);
					state_d = msps_pkg::ST_FIN;
				end else begin
					// restoring divide, one quotient bit a cycle
					trial = {rem_q, quo_q[DW-1]};
					if (trial >= {1'b0, dvs_q}) begin
						rem_d = 16'(trial - {1'b0, dvs_q});
						quo_d = {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_d = trial[15:0];
						quo_d = {quo_q[DW-2:0], 1'b0};
					end
					cnt_d = cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_d = msps_pkg::ST_FIN;
				end
			end
			msps_pkg::ST_FIN: begin
				qs = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
				load_res = 1'b1;
				res_d.status = msps_pkg::STAT_OK;
				res_d.read_value = 16'sd0;
				if (op_q == msps_pkg::OP_WRITE) begin
					wv = signed'({qs[DW], qs}) + signed'({10'b0, min_rd});
					new_w = clamp_w(wv, min_rd, max_rd);
					pw_d[addr_q] = new_w;
					total_d = total_q - {4'b0, pw_rd} + {4'b0, new_w};
				end else if (qs > 25'sd32767) begin
					res_d.read_value = 16'sh7FFF;
				end else if (qs < -25'sd32768) begin
					res_d.read_value = 16'sh8000;
				end else begin
					res_d.read_value = qs[15:0];
				end
				state_d = msps_pkg::ST_IDLE;
			end
			default: state_d = msps_pkg::ST_IDLE;
		endcase

		if (load_res) begin
			res_vld_d = 1'b1;
			res_d.pulse_lines = lines_d[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msps_pkg::ST_IDLE;
			slot_q <= '0;
			time_q <= msps_pkg::DEFAULT_RST;
			en_q <= '0;
			for (int i = 0; i < CHANNELS; i++) pw_q[i] <= msps_pkg::DEFAULT_RST;
			total_q <= TOTAL_RST;
			lines_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_q <= slot_d;
			time_q <= time_d;
			en_q <= en_d;
			pw_q <= pw_d;
			total_q <= total_d;
			lines_q <= lines_d;
			res_vld_q <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		min_q <= min_d;
		max_q <= max_d;
		op_q <= op_d;
		addr_q <= addr_d;
		mul_a_q <= mul_a_d;
		mul_b_q <= mul_b_d;
		dvs_q <= dvs_d;
		dneg_q <= dneg_d;
		neg_q <= neg_d;
		rem_q <= rem_d;
		quo_q <= quo_d;
		cnt_q <= cnt_d;
		res_q <= res_d;
	end

endmodule

### rtl/core/multiplexed_servo_pulse_sequencer.sv
// Most beats finish in the state that takes them; a write with an angle steps through
//   take, multiply, scale by 1/180 and finish, and read_deg through take, multiply, divide, finish.
// Throughput: one beat per cycle into the two-entry input queue while it is not full; the executor
//   retires one beat per cycle while results are popped, and none while an angle write or read_deg runs.
// Reset (arst_n low, asynchronous): queues empty, all lines low, no channel attached,
//   every width and the timer at 1500 us, frame 20000 us, slot 0.
module multiplexed_servo_pulse_sequencer #(
	parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	// input queue side
	input logic push,
	input msps_pkg::item_t item,
	output logic full,
	// result queue side
	output logic empty,
	input logic pop,
	output msps_pkg::result_t result,
	// configuration writes
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data
);

	logic [15:0] refresh_q, default_q;
	logic cmd_vld, cmd_take, res_vld;
	msps_pkg::cmd_t cmd;

	// Frame and default width registers; write them only while the block is quiet (the block does not enforce this).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= msps_pkg::REFRESH_RST;
			default_q <= msps_pkg::DEFAULT_RST;
		end else if (cfg_we) begin
			if (cfg_index == msps_pkg::CFG_REFRESH) refresh_q <= cfg_data;
			if (cfg_index == msps_pkg::CFG_DEFAULT) default_q <= cfg_data;
		end
	end

	// Front: take beats in, sort them by kind (tick, channel op, bad channel, no-op)
	// and hold them in a short queue so the host can keep pushing while the divider runs, until it is full.
	msps_front #(.CHANNELS(CHANNELS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.cmd_vld(cmd_vld),
		.cmd(cmd),
		.cmd_take(cmd_take)
	);

	// Back: run the slot timer and channel tables, and hold the result register.
	// While idle, a new beat can be taken in the cycle that the waiting result is popped.
	msps_back #(.CHANNELS(CHANNELS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_vld(cmd_vld),
		.cmd(cmd),
		.cmd_take(cmd_take),
		.refresh_us(refresh_q),
		.default_us(default_q),
		.res_vld(res_vld),
		.res(result),
		.res_take(pop)
	);

	assign empty = !res_vld;

	// Executor never takes a beat while an unpopped result would be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> (empty || pop))
		else $error("executor took a beat over a waiting result");

	// Executor only takes what the front queue offers.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_vld)
		else $error("executor took from an empty queue");

	// Status code three is never produced.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status != 2'd3))
		else $error("undefined status code");

endmodule
